// ===== rtl/keyword_tokenizer_top_macros.svh =====
// Assertion macros for the keyword tokenizer.
// Each check samples on the rising edge of clock and is off while reset is high.
`ifndef KEYWORD_TOKENIZER_TOP_MACROS_SVH
`define KEYWORD_TOKENIZER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Property that holds in every cycle.
`define KWT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("keyword tokenizer check failed");

// Antecedent in one cycle implies the consequent in the next.
`define KWT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keyword tokenizer sequence check failed");

`else

`define KWT_ASSERT(label, prop)
`define KWT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/kwt_pkg.sv =====
package kwt_pkg;

   // Default sizing of the token and line storage
   localparam int KEY_CHARS_DEF   = 20;
   localparam int TOKEN_CHARS_DEF = 24;
   localparam int LINE_CHARS_DEF  = 128;

   // Field widths of a beat
   localparam int CH_W    = 8;
   localparam int TYPE_W  = 5;
   localparam int INDEX_W = 7;
   localparam int LEN_W   = 5;

   // Byte codes
   localparam logic [CH_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CH_W-1:0] CH_SEMI    = 8'h3B;
   localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [CH_W-1:0] CASE_FOLD  = 8'h20;

   // Token type codes
   localparam logic [TYPE_W-1:0] TOK_GENERIC   = 5'd0;
   localparam logic [TYPE_W-1:0] TOK_SEMICOLON = 5'd16;

   // Word list: position t carries type code t+1
   localparam int NUM_WORDS = 17;
   localparam int WORD_MAX  = 6;
   localparam int WLEN_W    = 3;

   localparam logic [WLEN_W-1:0] WORD_LEN [NUM_WORDS] = '{
      3'd6, 3'd4, 3'd5, 3'd2, 3'd5, 3'd3, 3'd6, 3'd3, 3'd6,
      3'd6, 3'd6, 3'd6, 3'd4, 3'd5, 3'd1, 3'd1, 3'd1
   };

   localparam logic [CH_W-1:0] WORD_TEXT [NUM_WORDS][WORD_MAX] = '{
      '{"C", "R", "E", "A", "T", "E"},
      '{"D", "R", "O", "P", 8'h00, 8'h00},
      '{"A", "L", "T", "E", "R", 8'h00},
      '{"D", "B", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"T", "A", "B", "L", "E", 8'h00},
      '{"R", "O", "W", 8'h00, 8'h00, 8'h00},
      '{"C", "O", "L", "U", "M", "N"},
      '{"A", "D", "D", 8'h00, 8'h00, 8'h00},
      '{"S", "E", "L", "E", "C", "T"},
      '{"U", "P", "D", "A", "T", "E"},
      '{"I", "N", "S", "E", "R", "T"},
      '{"D", "E", "L", "E", "T", "E"},
      '{"F", "R", "O", "M", 8'h00, 8'h00},
      '{"W", "H", "E", "R", "E", 8'h00},
      '{"*", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{";", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   // Result queue
   localparam int FIFO_DEPTH = 4;

   typedef struct packed {
      logic [TYPE_W-1:0]  token_type;
      logic [INDEX_W-1:0] token_index;
      logic [LEN_W-1:0]   token_length;
      logic               run_last;
      logic               line_end;
   } rsp_entry_type;

endpackage

// ===== rtl/kwt_req_if.sv =====
interface kwt_req_if import kwt_pkg::*;;
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink (input valid, input ch, output ready);
endinterface

// ===== rtl/kwt_rsp_if.sv =====
interface kwt_rsp_if import kwt_pkg::*;;
   logic               valid;
   logic               ready;
   logic [TYPE_W-1:0]  token_type;
   logic [INDEX_W-1:0] token_index;
   logic [LEN_W-1:0]   token_length;
   logic               run_last;
   logic               line_end;

   modport source (output valid, output token_type, output token_index, output token_length,
                   output run_last, output line_end, input ready);
   modport sink (input valid, input token_type, input token_index, input token_length,
                 input run_last, input line_end, output ready);
endinterface

// ===== rtl/keyword_tokenizer_top.sv =====
// Keyword tokenizer: takes one text byte per req beat and emits tokens on rsp. A space or
// a zero byte closes the pending token; a semicolon closes it (if non-empty) and then
// forms its own token; any other byte is appended. Tokens are matched case-insensitively
// against 14 keywords and the symbols * ; =, otherwise GENERIC, and carry their index in
// the line and their length (saturating at TOKEN_CHARS). A zero byte, or any byte after
// LINE_CHARS bytes of a line, ends the line with line_end set and returns the token and
// line counters to reset. Classification runs from registered token state in the same
// cycle the byte arrives, so a byte is taken every cycle while req.ready is high; each
// byte writes its 0, 1 or 2 results into a four-entry result queue that drains one beat
// per cycle while rsp.ready is high. req.ready is high while the queue holds at most two
// results, so the sustained rate is one byte per cycle as long as results are taken.
`include "keyword_tokenizer_top_macros.svh"

module keyword_tokenizer_top import kwt_pkg::*; #(
   parameter int KEY_CHARS   = KEY_CHARS_DEF,
   parameter int TOKEN_CHARS = TOKEN_CHARS_DEF,
   parameter int LINE_CHARS  = LINE_CHARS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   kwt_req_if.sink   req,
   kwt_rsp_if.source rsp
);

   localparam int TC_W      = $clog2(TOKEN_CHARS + 1);
   localparam int LC_W      = $clog2(LINE_CHARS + 1);
   localparam int KC_W      = $clog2(KEY_CHARS + 1);
   localparam int KC_IDX_W  = $clog2(KEY_CHARS);
   localparam int EXT_W     = (TC_W > KC_W) ? TC_W : KC_W;
   localparam int PTR_W     = $clog2(FIFO_DEPTH);
   localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);

   // Token and line state
   logic [CH_W-1:0]    key_ff [KEY_CHARS];
   logic [TC_W-1:0]    token_chars_ff, token_chars_in;
   logic [INDEX_W-1:0] token_count_ff, token_count_in;
   logic [LC_W-1:0]    line_chars_ff, line_chars_in;

   // Result queue
   rsp_entry_type      fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic               req_beat;
   logic               rsp_beat;
   logic [CH_W-1:0]    c_eff;
   logic [CH_W-1:0]    c_upper;
   logic [TYPE_W-1:0]  cls;
   logic [EXT_W-1:0]   tchars_ext;
   logic               key_we;
   logic [1:0]         n_push;
   rsp_entry_type      res0, res1;
   rsp_entry_type      head;

   assign req_beat   = req.valid && req.ready;
   assign rsp_beat   = rsp.valid && rsp.ready;
   assign req.ready  = (count_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign tchars_ext = EXT_W'(token_chars_ff);

   // Classify the pending token; the lowest matching word wins
   always_comb begin
      logic m;
      cls = TOK_GENERIC;
      for (int t = NUM_WORDS - 1; t >= 0; t--) begin
         m = (token_chars_ff == TC_W'(WORD_LEN[t]));
         for (int i = 0; i < WORD_MAX; i++) begin
            if ((WLEN_W'(i) < WORD_LEN[t]) && (key_ff[i] != WORD_TEXT[t][i])) begin
               m = 1'b0;
            end
         end
         if (m) begin
            cls = TYPE_W'(t + 1);
         end
      end
   end

   // Fold lower-case letters for the key buffer
   always_comb begin
      c_upper = req.ch;
      if ((req.ch >= CH_LOWER_A) && (req.ch <= CH_LOWER_Z)) begin
         c_upper = req.ch - CASE_FOLD;
      end
   end

   // Advance token state and build the results of the accepted byte
   always_comb begin
      c_eff          = req.ch;
      line_chars_in  = line_chars_ff;
      token_chars_in = token_chars_ff;
      token_count_in = token_count_ff;
      key_we         = 1'b0;
      n_push         = 2'd0;
      res0           = '{cls, token_count_ff, LEN_W'(token_chars_ff), 1'b1, 1'b0};
      res1           = '{TOK_SEMICOLON, token_count_ff + 7'd1, LEN_W'(1), 1'b1, 1'b0};
      if (req_beat) begin
         if (line_chars_ff >= LC_W'(LINE_CHARS)) begin
            c_eff = CH_NUL;
         end else begin
            line_chars_in = line_chars_ff + LC_W'(1);
         end
         unique case (c_eff)
            CH_NUL: begin
               res0.line_end  = 1'b1;
               n_push         = 2'd1;
               token_chars_in = '0;
               token_count_in = '0;
               line_chars_in  = '0;
            end
            CH_SPACE: begin
               n_push         = 2'd1;
               token_chars_in = '0;
               token_count_in = token_count_ff + 7'd1;
            end
            CH_SEMI: begin
               token_chars_in = '0;
               if (token_chars_ff != '0) begin
                  res0.run_last  = 1'b0;
                  n_push         = 2'd2;
                  token_count_in = token_count_ff + 7'd2;
               end else begin
                  res0           = '{TOK_SEMICOLON, token_count_ff, LEN_W'(1), 1'b1, 1'b0};
                  n_push         = 2'd1;
                  token_count_in = token_count_ff + 7'd1;
               end
            end
            default: begin
               key_we = (tchars_ext < EXT_W'(KEY_CHARS));
               if (token_chars_ff < TC_W'(TOKEN_CHARS)) begin
                  token_chars_in = token_chars_ff + TC_W'(1);
               end
            end
         endcase
      end
   end

   // Hold token and line counters
   always_ff @(posedge clock) begin
      if (reset) begin
         token_chars_ff <= '0;
         token_count_ff <= '0;
         line_chars_ff  <= '0;
      end else begin
         token_chars_ff <= token_chars_in;
         token_count_ff <= token_count_in;
         line_chars_ff  <= line_chars_in;
      end
   end

   // Store the folded byte; entries past the token length are never compared
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_ff[tchars_ext[KC_IDX_W-1:0]] <= c_upper;
      end
   end

   // Queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + PTR_W'(rsp_beat);
      count_in  = count_ff + CNT_W'(n_push) - CNT_W'(rsp_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write one or two result entries
   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (n_push == 2'd2) begin
         fifo_ff[wr_ptr_ff + PTR_W'(1)] <= res1;
      end
   end

   // Drive the result beat from the queue head
   assign head             = fifo_ff[rd_ptr_ff];
   assign rsp.valid        = (count_ff != '0);
   assign rsp.token_type   = head.token_type;
   assign rsp.token_index  = head.token_index;
   assign rsp.token_length = head.token_length;
   assign rsp.run_last     = head.run_last;
   assign rsp.line_end     = head.line_end;

   `KWT_ASSERT(a_fifo_bound, count_ff <= CNT_W'(FIFO_DEPTH))
   `KWT_ASSERT(a_line_bound, line_chars_ff <= LC_W'(LINE_CHARS))
   `KWT_ASSERT(a_pair_only_semi, (n_push != 2'd2) || (c_eff == CH_SEMI))
   `KWT_ASSERT(a_end_is_last, !(rsp.valid && rsp.line_end) || rsp.run_last)
   `KWT_ASSERT_NEXT(a_line_reset, req_beat && (c_eff == CH_NUL),
      (token_count_ff == '0) && (token_chars_ff == '0) && (line_chars_ff == '0))

endmodule

// ===== tb/sv/keyword_tokenizer_top_tb.sv =====
module keyword_tokenizer_top_tb;
   import kwt_pkg::*;

   localparam int RANDOM_BYTES = 1250;
   localparam int CYCLE_LIMIT  = 400_000;
   localparam int DRAIN_CYCLES = 20;

   // Expected token stream of the tokenizer, fed by accepted byte beats
   class token_scoreboard;
      string              words[$];
      rsp_entry_type      expected_tokens[$];
      logic [CH_W-1:0]    key_buf[KEY_CHARS_DEF];
      int                 tok_chars;
      logic [INDEX_W-1:0] tok_count;
      int                 line_taken;
      int                 errors;
      int                 checked;

      function new();
         // type code of an entry is its position plus one
         words = '{"CREATE", "DROP", "ALTER", "DB", "TABLE", "ROW", "COLUMN", "ADD",
                   "SELECT", "UPDATE", "INSERT", "DELETE", "FROM", "WHERE", "*", ";", "="};
         errors = 0;
         checked = 0;
         restart_line();
      endfunction

      function void clear_token();
         foreach (key_buf[i]) key_buf[i] = '0;
         tok_chars = 0;
      endfunction

      function void restart_line();
         clear_token();
         tok_count = '0;
         line_taken = 0;
      endfunction

      // Match the pending token against the word list; lengths must agree exactly
      function logic [TYPE_W-1:0] classify();
         bit hit;
         for (int t = 0; t < words.size(); t++) begin
            if (tok_chars == words[t].len()) begin
               hit = 1'b1;
               for (int i = 0; i < words[t].len(); i++) begin
                  if (key_buf[i] != words[t][i]) hit = 1'b0;
               end
               if (hit) return TYPE_W'(t + 1);
            end
         end
         return TOK_GENERIC;
      endfunction

      function void push_token(logic [TYPE_W-1:0] kind, int len, logic last, logic ends);
         rsp_entry_type e;
         e.token_type   = kind;
         e.token_index  = tok_count;
         e.token_length = LEN_W'(len);
         e.run_last     = last;
         e.line_end     = ends;
         expected_tokens.push_back(e);
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction

      // Advance the tokenizer state by one accepted byte
      function void note_byte(logic [CH_W-1:0] ch_in);
         logic [CH_W-1:0] c;
         c = ch_in;
         // a byte past the line limit closes the line like the zero byte
         if (line_taken >= LINE_CHARS_DEF) c = CH_NUL;
         else line_taken++;

         if (c == CH_NUL) begin
            push_token(classify(), tok_chars, 1'b1, 1'b1);
            restart_line();
         end else if (c == CH_SPACE) begin
            push_token(classify(), tok_chars, 1'b1, 1'b0);
            tok_count++;
            clear_token();
         end else if (c == CH_SEMI) begin
            // close a non-empty pending token first, then the semicolon itself
            if (tok_chars != 0) begin
               push_token(classify(), tok_chars, 1'b0, 1'b0);
               tok_count++;
            end
            push_token(TOK_SEMICOLON, 1, 1'b1, 1'b0);
            tok_count++;
            clear_token();
         end else begin
            if (tok_chars < KEY_CHARS_DEF)
               key_buf[tok_chars] = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_FOLD : c;
            if (tok_chars < TOKEN_CHARS_DEF) tok_chars++;
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      // Compare one token beat with the oldest expected token
      task check_token(rsp_entry_type got);
         rsp_entry_type want;
         checked++;
         if (expected_tokens.size() == 0) begin
            report($sformatf("token %0d arrived with none expected", checked));
            return;
         end
         want = expected_tokens.pop_front();
         if (got.token_type !== want.token_type)
            report($sformatf("token %0d type %0d, want %0d",
                             checked, got.token_type, want.token_type));
         if (got.token_index !== want.token_index)
            report($sformatf("token %0d index %0d, want %0d",
                             checked, got.token_index, want.token_index));
         if (got.token_length !== want.token_length)
            report($sformatf("token %0d length %0d, want %0d",
                             checked, got.token_length, want.token_length));
         if (got.run_last !== want.run_last)
            report($sformatf("token %0d run_last %b, want %b",
                             checked, got.run_last, want.run_last));
         if (got.line_end !== want.line_end)
            report($sformatf("token %0d line_end %b, want %b",
                             checked, got.line_end, want.line_end));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   kwt_req_if req ();
   kwt_rsp_if rsp ();

   keyword_tokenizer_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   token_scoreboard board;
   rsp_entry_type   got;
   logic [CH_W-1:0] text_line[$];
   int              idle_pct;
   int              stall_pct;
   int              cycle_count;

   always #5 clock = ~clock;

   // Hold off result beats at random
   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watch both channels from one process so byte and token beats stay ordered
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) board.note_byte(req.ch);
         if (rsp.valid && rsp.ready) begin
            got = {rsp.token_type, rsp.token_index, rsp.token_length, rsp.run_last,
                   rsp.line_end};
            board.check_token(got);
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [CH_W-1:0] mixed_case(logic [CH_W-1:0] b);
      if (b >= "A" && b <= "Z" && $urandom_range(1) == 1) return b + CASE_FOLD;
      return b;
   endfunction

   // Any byte that neither ends nor splits a token
   function automatic logic [CH_W-1:0] word_byte();
      logic [CH_W-1:0] b;
      do b = CH_W'($urandom_range(255));
      while (b == CH_NUL || b == CH_SPACE || b == CH_SEMI);
      return b;
   endfunction

   // Drive one byte beat, idling at random before it
   task automatic send_byte(logic [CH_W-1:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.ch    <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // Compose one line: mostly keyword sentences, some noise, semicolon runs and overlong lines
   task automatic build_line();
      int kind;
      int ntok;
      int pick;
      int w;
      text_line.delete();
      kind = $urandom_range(99);
      if (kind < 4) begin
         // overlong line: runs past the line limit without a zero byte
         repeat ($urandom_range(129, 140)) begin
            pick = $urandom_range(9);
            if (pick == 0) text_line.push_back(CH_SPACE);
            else if (pick == 1) text_line.push_back(CH_SEMI);
            else text_line.push_back(word_byte());
         end
      end else if (kind < 6) begin
         // a run of semicolons wraps the token index
         repeat ($urandom_range(128, 131)) text_line.push_back(CH_SEMI);
      end else if (kind < 16) begin
         repeat ($urandom_range(1, 30)) text_line.push_back(CH_W'($urandom_range(255)));
         text_line.push_back(CH_NUL);
      end else begin
         ntok = $urandom_range(1, 8);
         for (int k = 0; k < ntok; k++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               w = $urandom_range(board.words.size() - 1);
               for (int i = 0; i < board.words[w].len(); i++)
                  text_line.push_back(mixed_case(board.words[w][i]));
               // spoil the keyword now and then with a trailing byte
               if ($urandom_range(9) == 0) text_line.push_back(word_byte());
            end else if (pick < 75) begin
               repeat ($urandom_range(1, 8)) text_line.push_back(word_byte());
            end else if (pick < 85) begin
               repeat ($urandom_range(19, 30))
                  text_line.push_back(mixed_case(CH_W'("A" + $urandom_range(25))));
            end
            // an empty token leaves two separators side by side
            if (k < ntok - 1 || $urandom_range(1) == 1)
               text_line.push_back(($urandom_range(3) == 0) ? CH_SEMI : CH_SPACE);
         end
         text_line.push_back(CH_NUL);
      end
   endtask

   initial begin
      string opening;
      int    sent;
      int    phase;
      board = new();
      reset = 1'b1;
      req.valid = 1'b0;
      req.ch = '0;
      idle_pct = 0;
      stall_pct = 0;
      opening = "Db  ;x;* = wHeRe ";

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: mixed case, empty tokens, lone and closing semicolons, symbols,
      // a top-bit byte, a closed line and an empty line
      for (int i = 0; i < opening.len(); i++) send_byte(opening[i]);
      send_byte(8'hFF);
      send_byte(CH_NUL);
      send_byte(CH_NUL);

      // Random lines across the idling and stalling phases
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         phase = sent * 4 / RANDOM_BYTES;
         case (phase)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 87;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 87;
            end
            default: begin
               idle_pct = 11;
               stall_pct = 11;
            end
         endcase
         build_line();
         foreach (text_line[i]) send_byte(text_line[i]);
         sent += text_line.size();
      end
      req.valid <= 1'b0;

      // Drain outstanding tokens, then watch for strays
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
